// ===== design/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and codes for the k-way merge with key summing.
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam logic [1:0] KIND_RECORD  = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;

	localparam logic [6:0] RUNS_RESET = 7'd64;
	localparam int         RUN_LIMIT  = 64;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  request_run;
		logic [63:0] out_key;
		logic [63:0] out_value;
		logic [63:0] emitted_total;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_VREAD,
		ST_RESOLVE,
		ST_EMIT
	} state_t;

endpackage

// ===== design/kms_if.sv =====
// ----------------------------------------------------------------------------
// kms_if
// Valid/ready channels for input records and merge results.
// ----------------------------------------------------------------------------
interface kms_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  run_index;
	logic [63:0] record_key;
	logic [63:0] record_value;
	logic        run_finished;

	modport source (output valid, run_index, record_key, record_value, run_finished,
		input ready);
	modport sink (input valid, run_index, record_key, record_value, run_finished,
		output ready);
endinterface

interface kms_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  request_run;
	logic [63:0] out_key;
	logic [63:0] out_value;
	logic [63:0] emitted_total;
	logic        last;

	modport source (output valid, kind, request_run, out_key, out_value, emitted_total,
		last, input ready);
	modport sink (input valid, kind, request_run, out_key, out_value, emitted_total,
		last, output ready);
endinterface

// ===== design/kms_head_mem.sv =====
// ----------------------------------------------------------------------------
// kms_head_mem
// Head key/value storage: one write port, one shared registered read port.
// ----------------------------------------------------------------------------
module kms_head_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wkey,
	input  logic [63:0]   wval,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rkey,
	output logic [63:0]   rval
);

	logic [63:0] key_mem [DEPTH];
	logic [63:0] val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
		rkey <= key_mem[raddr];
		rval <= val_mem[raddr];
	end

endmodule

// ===== design/kway_merge_sum_duplicates.sv =====
// ----------------------------------------------------------------------------
// kway_merge_sum_duplicates
// K-way merge of sorted key/value runs; equal keys are summed.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  rec     | in  | run_index, record_key, record_value, run_finished
//  res     | out | kind, request_run, out_key, out_value, emitted_total, last
//  cfg     | in  | cfg_we, cfg_wdata (runs_in_use)
//
// A record that completes the set of heads starts a linear scan of lim entries
// (lim = clamped runs_in_use) of the head key memory through its single read port,
// then DRAIN, VREAD and RESOLVE, before EMIT; other records go from CHECK to IDLE.
// Results go out one beat a cycle while res.ready is high; rec.ready is low
// until all are taken. Reset clears control and presence bits at once; no clearing pass.
module kway_merge_sum_duplicates #(
	parameter int MAX_RUNS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [6:0]       cfg_wdata,
	kms_in_if.sink           rec,
	kms_out_if.source        res
);

	localparam int NRUNS = (MAX_RUNS < kms_pkg::RUN_LIMIT) ? MAX_RUNS : kms_pkg::RUN_LIMIT;
	localparam int IW    = $clog2(NRUNS);

	kms_pkg::state_t state_q, state_d;

	logic [6:0]       runs_q;
	logic [6:0]       lim;
	logic [NRUNS-1:0] present_q, exh_q;
	logic [IW-1:0]    cnt_q, best_q, idx_s1, raddr, widx;
	logic             vld_s1, found_q, all_loaded, rec_ok, rec_acc, res_acc;
	logic [63:0]      best_key_q, rkey, rval;
	logic [63:0]      acc_key_q, acc_sum_q, emitted_q;
	logic             acc_hold_q, rec_emit;
	kms_pkg::res_t    res0_q, res1_q, cur;
	logic             sel_q, two_q, scan_end, better;

	always_comb begin
		lim = runs_q;
		if (runs_q == 7'd0) lim = 7'd1;
		if (runs_q > 7'(NRUNS)) lim = 7'(NRUNS);
	end

	assign widx    = rec.run_index[IW-1:0];
	assign rec_ok  = ({1'b0, rec.run_index} < lim) && !present_q[widx] && !exh_q[widx];
	assign rec_acc = rec.valid && rec.ready;
	assign res_acc = res.valid && res.ready;

	always_comb begin
		all_loaded = 1'b1;
		for (int i = 0; i < NRUNS; i++)
			if ((7'(i) < lim) && !present_q[i] && !exh_q[i]) all_loaded = 1'b0;
	end

	assign scan_end = (7'(cnt_q) == lim - 7'd1);
	assign raddr    = (state_q == kms_pkg::ST_SCAN) ? cnt_q : best_q;
	assign better   = vld_s1 && present_q[idx_s1] && (!found_q || rkey < best_key_q);
	assign rec_emit = acc_hold_q && (acc_sum_q != 64'd0);

	kms_head_mem #(.DEPTH(NRUNS), .AW(IW)) u_mem (
		.clk   (clk),
		.we    (rec_acc && rec_ok && !rec.run_finished),
		.waddr (widx),
		.wkey  (rec.record_key),
		.wval  (rec.record_value),
		.raddr (raddr),
		.rkey  (rkey),
		.rval  (rval)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kms_pkg::ST_IDLE:    if (rec_acc && rec_ok) state_d = kms_pkg::ST_CHECK;
			kms_pkg::ST_CHECK:   state_d = all_loaded ? kms_pkg::ST_SCAN : kms_pkg::ST_IDLE;
			kms_pkg::ST_SCAN:    if (scan_end) state_d = kms_pkg::ST_DRAIN;
			kms_pkg::ST_DRAIN:   state_d = kms_pkg::ST_VREAD;
			kms_pkg::ST_VREAD:   state_d = kms_pkg::ST_RESOLVE;
			kms_pkg::ST_RESOLVE: state_d = kms_pkg::ST_EMIT;
			kms_pkg::ST_EMIT:    if (res_acc && (sel_q || !two_q)) state_d = kms_pkg::ST_IDLE;
			default:             state_d = kms_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rec.ready = 1'b0;
		res.valid = 1'b0;
		case (state_q)
			kms_pkg::ST_IDLE: rec.ready = 1'b1;
			kms_pkg::ST_EMIT: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign cur               = sel_q ? res1_q : res0_q;
	assign res.kind          = cur.kind;
	assign res.request_run   = cur.request_run;
	assign res.out_key       = cur.out_key;
	assign res.out_value     = cur.out_value;
	assign res.emitted_total = cur.emitted_total;
	assign res.last          = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kms_pkg::ST_IDLE;
			runs_q     <= kms_pkg::RUNS_RESET;
			present_q  <= '0;
			exh_q      <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			acc_hold_q <= 1'b0;
			acc_key_q  <= '0;
			acc_sum_q  <= '0;
			emitted_q  <= '0;
			sel_q      <= 1'b0;
			two_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) runs_q <= cfg_wdata;
			if (rec_acc && rec_ok) begin
				if (rec.run_finished) exh_q[widx] <= 1'b1;
				else present_q[widx] <= 1'b1;
			end
			vld_s1 <= (state_q == kms_pkg::ST_SCAN);
			if (state_q == kms_pkg::ST_CHECK) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if (state_q == kms_pkg::ST_SCAN) cnt_q <= cnt_q + IW'(1);
			if (better) found_q <= 1'b1;
			if (state_q == kms_pkg::ST_RESOLVE) begin
				sel_q     <= 1'b0;
				// an equal key only adds to the sum, no record beat is emitted
				emitted_q <= emitted_q + {63'd0, rec_emit &&
					!(found_q && acc_hold_q && (acc_key_q == best_key_q))};
				if (!found_q) begin
					two_q      <= rec_emit;
					acc_hold_q <= 1'b0;
					acc_sum_q  <= '0;
				end else begin
					present_q[best_q] <= 1'b0;
					if (acc_hold_q && acc_key_q == best_key_q) begin
						two_q     <= 1'b0;
						acc_sum_q <= acc_sum_q + rval;
					end else begin
						two_q      <= rec_emit;
						acc_key_q  <= best_key_q;
						acc_sum_q  <= rval;
						acc_hold_q <= 1'b1;
					end
				end
			end
			if (state_q == kms_pkg::ST_EMIT && res_acc) sel_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == kms_pkg::ST_SCAN) idx_s1 <= cnt_q;
		if (better) begin
			best_q     <= idx_s1;
			best_key_q <= rkey;
		end
		if (state_q == kms_pkg::ST_RESOLVE) begin
			kms_pkg::res_t r_rec, r_tail;
			logic          same;
			same = found_q && acc_hold_q && (acc_key_q == best_key_q);
			r_rec           = '0;
			r_rec.kind      = kms_pkg::KIND_RECORD;
			r_rec.out_key   = acc_key_q;
			r_rec.out_value = acc_sum_q;
			r_tail          = '0;
			r_tail.last     = 1'b1;
			if (found_q) begin
				r_tail.kind        = kms_pkg::KIND_REQUEST;
				r_tail.request_run = 6'(best_q);
			end else begin
				r_tail.kind          = kms_pkg::KIND_DONE;
				r_tail.emitted_total = emitted_q + {63'd0, rec_emit};
			end
			if (rec_emit && !same) begin
				res0_q <= r_rec;
				res1_q <= r_tail;
			end else begin
				res0_q <= r_tail;
				res1_q <= r_tail;
			end
		end
	end

endmodule

// ===== design/kms_checker.sv =====
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks on the merge block, bound into kway_merge_sum_duplicates.
// ----------------------------------------------------------------------------
module kms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  kind,
	input logic [63:0] out_key,
	input logic [63:0] out_value,
	input logic [63:0] emitted_total,
	input logic        last
);

	// input is never taken while a result beat is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_ready && res_valid)) else $error("input ready while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_key) && $stable(out_value)
		&& $stable(kind) && $stable(last)) else $error("stalled result changed");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == kms_pkg::KIND_RECORD |-> out_value != 64'd0 && !last)
		else $error("record beat with zero sum or marked last");

	a_req_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == kms_pkg::KIND_REQUEST |-> last && out_key == 64'd0
		&& emitted_total == 64'd0) else $error("malformed request beat");

endmodule

bind kway_merge_sum_duplicates kms_checker u_kms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rec_ready     (rec.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.kind          (res.kind),
	.out_key       (res.out_key),
	.out_value     (res.out_value),
	.emitted_total (res.emitted_total),
	.last          (res.last)
);

// ===== test/merge_checker.sv =====
// ----------------------------------------------------------------------------
// merge_checker
// Watches the record and result channels of the k-way merge, predicts every
// result beat from the accepted record beats and compares field by field.
// ----------------------------------------------------------------------------
module merge_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	kms_in_if          rec,
	kms_out_if         res,
	output int         fail_count,
	output int         results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0]   head_key [kms_pkg::RUN_LIMIT];
	logic [63:0]   head_val [kms_pkg::RUN_LIMIT];
	bit            head_held [kms_pkg::RUN_LIMIT];
	bit            run_ended [kms_pkg::RUN_LIMIT];
	logic [63:0]   sum_key;
	logic [63:0]   sum_total;
	bit            sum_open;
	logic [63:0]   records_out;
	logic [6:0]    run_count;
	kms_pkg::res_t merge_expect_q [$];

	function automatic int live_runs();
		if (run_count < 7'd1) return 1;
		if (run_count > 7'(kms_pkg::RUN_LIMIT)) return kms_pkg::RUN_LIMIT;
		return int'(run_count);
	endfunction

	function automatic kms_pkg::res_t make_beat(logic [1:0] kind, logic [5:0] run,
		logic [63:0] key, logic [63:0] val, logic [63:0] tot);
		kms_pkg::res_t b;
		b.kind = kind;
		b.request_run = run;
		b.out_key = key;
		b.out_value = val;
		b.emitted_total = tot;
		b.last = 1'b0;
		return b;
	endfunction

	task automatic close_sum();
		if (sum_open && sum_total != 64'd0) begin
			merge_expect_q = {merge_expect_q,
				make_beat(kms_pkg::KIND_RECORD, 6'd0, sum_key, sum_total, 64'd0)};
			records_out += 64'd1;
		end
	endtask

	task automatic merge_record(logic [5:0] idx, logic [63:0] key, logic [63:0] val,
		logic fin);
		int lim;
		int best;
		bit found;
		lim = live_runs();
		best = 0;
		found = 0;
		if (int'(idx) >= lim) return;
		if (head_held[idx] || run_ended[idx]) return;
		if (fin) begin
			run_ended[idx] = 1;
		end else begin
			head_key[idx] = key;
			head_val[idx] = val;
			head_held[idx] = 1;
		end
		for (int i = 0; i < lim; i++)
			if (!head_held[i] && !run_ended[i]) return;
		for (int i = 0; i < lim; i++) begin
			if (head_held[i] && (!found || head_key[i] < head_key[best])) begin
				best = i;
				found = 1;
			end
		end
		if (!found) begin
			close_sum();
			sum_open = 0;
			sum_total = 64'd0;
			merge_expect_q = {merge_expect_q,
				make_beat(kms_pkg::KIND_DONE, 6'd0, 64'd0, 64'd0, records_out)};
		end else begin
			if (sum_open && sum_key == head_key[best]) begin
				sum_total += head_val[best];
			end else begin
				close_sum();
				sum_key = head_key[best];
				sum_total = head_val[best];
				sum_open = 1;
			end
			head_held[best] = 0;
			merge_expect_q = {merge_expect_q,
				make_beat(kms_pkg::KIND_REQUEST, 6'(best), 64'd0, 64'd0, 64'd0)};
		end
		merge_expect_q[merge_expect_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kms_pkg::res_t got;
		kms_pkg::res_t want;
		if (!arst_n) begin
			for (int i = 0; i < kms_pkg::RUN_LIMIT; i++) begin
				head_key[i] = '0;
				head_val[i] = '0;
				head_held[i] = 0;
				run_ended[i] = 0;
			end
			sum_key = '0;
			sum_total = '0;
			sum_open = 0;
			records_out = '0;
			run_count = kms_pkg::RUNS_RESET;
			merge_expect_q.delete();
			fail_count = 0;
			results_owed = 0;
		end else begin
			if (cfg_we)
				run_count = cfg_wdata;
			if (rec.valid && rec.ready)
				merge_record(rec.run_index, rec.record_key, rec.record_value, rec.run_finished);
			if (res.valid && res.ready) begin
				got.kind = res.kind;
				got.request_run = res.request_run;
				got.out_key = res.out_key;
				got.out_value = res.out_value;
				got.emitted_total = res.emitted_total;
				got.last = res.last;
				if (merge_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: kind %0d run %0d key %h val %h tot %0d last %b",
							got.kind, got.request_run, got.out_key, got.out_value,
							got.emitted_total, got.last);
				end else begin
					want = merge_expect_q.pop_front();
					if (got.kind !== want.kind || got.request_run !== want.request_run ||
						got.out_key !== want.out_key || got.out_value !== want.out_value ||
						got.emitted_total !== want.emitted_total || got.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("exp: kind %0d run %0d key %h val %h tot %0d last %b",
								want.kind, want.request_run, want.out_key, want.out_value,
								want.emitted_total, want.last);
							$display("got: kind %0d run %0d key %h val %h tot %0d last %b",
								got.kind, got.request_run, got.out_key, got.out_value,
								got.emitted_total, got.last);
						end
					end
				end
			end
			results_owed = merge_expect_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sorted runs into the k-way merge, answering its refill requests,
// with noise beats, several run counts and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] val;
	} kv_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	int         fail_count;
	int         results_owed;

	kms_in_if  rec ();
	kms_out_if res ();

	kway_merge_sum_duplicates #(.MAX_RUNS(kms_pkg::RUN_LIMIT)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rec       (rec),
		.res       (res)
	);

	merge_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.rec          (rec),
		.res          (res),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	kv_t run_q [kms_pkg::RUN_LIMIT][$];
	int  refill_q [$];
	int  done_seen;
	int  beats_sent;
	int  tx_idle;
	int  rx_idle;
	bit  hold_go;
	int  hold_left;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#4000000;
		$display("kway_merge_sum_duplicates: mismatch");
		$finish;
	end

	// refill requests and done beats steer the sender
	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			if (res.kind == kms_pkg::KIND_REQUEST)
				refill_q = {refill_q, int'(res.request_run)};
			else if (res.kind == kms_pkg::KIND_DONE)
				done_seen++;
		end
	end

	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_left = 500;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_beat(int idx, logic [63:0] key, logic [63:0] val, logic fin);
		while ($urandom_range(99) < tx_idle) begin
			rec.valid <= 1'b0;
			@(posedge clk);
		end
		rec.valid <= 1'b1;
		rec.run_index <= 6'(idx);
		rec.record_key <= key;
		rec.record_value <= val;
		rec.run_finished <= fin;
		do @(posedge clk); while (!rec.ready);
		beats_sent++;
		if (beats_sent == 200)
			hold_go = 1;
		if (beats_sent < 300) begin
			tx_idle = 30;
			rx_idle = 78;
		end else if (beats_sent < 600) begin
			tx_idle = 78;
			rx_idle = 30;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_head(int r);
		kv_t h;
		if (run_q[r].size() == 0) begin
			send_beat(r, rand64(), rand64(), 1'b1);
		end else begin
			h = run_q[r].pop_front();
			send_beat(r, h.key, h.val, 1'b0);
		end
	endtask

	task automatic fill_run(int r, int maxlen);
		int len;
		bit wide;
		logic [63:0] k;
		logic [63:0] v;
		logic [63:0] step;
		kv_t e;
		len = $urandom_range(maxlen, 0);
		wide = ($urandom_range(3) == 0);
		k = wide ? (rand64() >> $urandom_range(8, 1)) : 64'($urandom_range(3));
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: v = 64'($urandom_range(5));
				1: v = rand64();
				default: v = 64'($urandom_range(1000));
			endcase
			e.key = k;
			e.val = v;
			run_q[r] = {run_q[r], e};
			if ($urandom_range(4) == 0) begin
				// same key again with the negated value: sum cancels to zero
				e.val = 64'd0 - v;
				run_q[r] = {run_q[r], e};
			end
			step = wide ? (rand64() >> $urandom_range(40, 4)) : 64'($urandom_range(2));
			if (k > 64'hFFFF_FFFF_FFFF_FFFF - step)
				break;
			k += step;
		end
	endtask

	task automatic noise_beat(int lo, int hi);
		int idx;
		idx = (hi < kms_pkg::RUN_LIMIT) ? $urandom_range(kms_pkg::RUN_LIMIT - 1, hi)
			: $urandom_range(lo - 1, 0);
		send_beat(idx, rand64(), rand64(), 1'($urandom_range(1)));
	endtask

	// fresh runs lo..hi-1 are loaded in random order, then refilled on request
	task automatic merge_session(int lo, int hi);
		int order [$];
		int done_mark;
		int r;
		done_mark = done_seen;
		for (int i = lo; i < hi; i++)
			order = {order, i};
		order.shuffle();
		for (int i = 0; i < order.size(); i++) begin
			send_head(order[i]);
			if (i < order.size() - 1 && $urandom_range(7) == 0)
				send_beat(order[i], rand64(), rand64(), 1'($urandom_range(1)));
			if ((lo > 0 || hi < kms_pkg::RUN_LIMIT) && $urandom_range(9) == 0)
				noise_beat(lo, hi);
		end
		while (done_seen == done_mark) begin
			if (refill_q.size() != 0) begin
				r = refill_q.pop_front();
				if ((lo > 0 || hi < kms_pkg::RUN_LIMIT) && $urandom_range(19) == 0)
					noise_beat(lo, hi);
				send_head(r);
			end else begin
				rec.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic write_runs(logic [6:0] n);
		rec.valid <= 1'b0;
		while (results_owed != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int guard;
		kv_t e;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rec.valid = 1'b0;
		rec.run_index = '0;
		rec.record_key = '0;
		rec.record_value = '0;
		rec.run_finished = 1'b0;
		res.ready = 1'b0;
		done_seen = 0;
		beats_sent = 0;
		tx_idle = 30;
		rx_idle = 78;
		hold_go = 0;
		hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single run: zero key, cancelling sum, wrapping sum, top key and value
		write_runs(7'd1);
		e = '{key: 64'd0, val: 64'hFFFF_FFFF_FFFF_FFFF}; run_q[0] = {run_q[0], e};
		e = '{key: 64'd0, val: 64'd1};                   run_q[0] = {run_q[0], e};
		e = '{key: 64'd5, val: 64'h8000_0000_0000_0000}; run_q[0] = {run_q[0], e};
		e = '{key: 64'd5, val: 64'h8000_0000_0000_0001}; run_q[0] = {run_q[0], e};
		e = '{key: 64'hFFFF_FFFF_FFFF_FFFF, val: 64'hFFFF_FFFF_FFFF_FFFF};
		run_q[0] = {run_q[0], e};
		send_beat(9, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		merge_session(0, 1);

		// count of zero clamps to one run; that run has ended, beat is dropped
		write_runs(7'd0);
		send_beat(0, 64'd3, 64'd3, 1'b0);
		send_beat(63, 64'd3, 64'd3, 1'b1);

		// two runs, both empty: done straight away
		write_runs(7'd3);
		merge_session(1, 3);

		write_runs(7'd12);
		for (int r = 3; r < 12; r++)
			fill_run(r, 20);
		merge_session(3, 12);

		write_runs(7'd30);
		for (int r = 12; r < 30; r++)
			fill_run(r, 20);
		merge_session(12, 30);

		write_runs(7'd64);
		for (int r = 30; r < 64; r++)
			fill_run(r, 30);
		merge_session(30, 64);

		// over the limit clamps to all runs, all ended: beats are dropped
		write_runs(7'd127);
		send_beat(5, rand64(), rand64(), 1'b0);
		send_beat(62, rand64(), rand64(), 1'b1);
		rec.valid <= 1'b0;

		guard = 0;
		while (results_owed != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("kway_merge_sum_duplicates: match");
		end else begin
			$display("kway_merge_sum_duplicates: mismatch");
		end
		$finish;
	end

endmodule
